### sv/pidaw_pkg.sv
// ---------------------------------------------------------------------------
// pidaw_pkg
// Shared constants, register indexes and types for the PID controller.
// ---------------------------------------------------------------------------
package pidaw_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // shared multiply/divide unit geometry
    localparam int ACC_W = 96;   // product / dividend / quotient width
    localparam int SRC_W = 64;   // multiplicand width
    localparam int MUL_W = 32;   // multiplier width, one bit per cycle
    localparam int OPB_W = 33;   // divisor width
    localparam int CNT_W = 7;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU = 3'd6;

    localparam logic [16:0] BAND_RST       = 17'h1FFFF;
    localparam logic [15:0] DRIVE_LOW_RST  = 16'h8000;
    localparam logic [15:0] DRIVE_HIGH_RST = 16'h7FFF;

    localparam logic [63:0] TERM_LIM  = 64'h2000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [47:0] RATE_MAX  = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic start;
        logic div;
    } mdu_req_t;

endpackage

### sv/pidaw_if.sv
// ---------------------------------------------------------------------------
// pidaw_if
// Valid/ready channels for controller updates and drive results.
// ---------------------------------------------------------------------------
interface pidaw_in_if #(
    parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic        [31:0]             elapsed_us;

    modport source (output valid, target, sample, elapsed_us, input ready);
    modport sink   (input valid, target, sample, elapsed_us, output ready);
endinterface

interface pidaw_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               saturated;

    modport source (output valid, drive, saturated, input ready);
    modport sink   (input valid, drive, saturated, output ready);
endinterface

### sv/pidaw_mdu.sv
// ---------------------------------------------------------------------------
// pidaw_mdu
// Shared radix-2 unsigned multiply (shift-add) and restoring divide unit.
// ---------------------------------------------------------------------------
module pidaw_mdu (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pidaw_pkg::mdu_req_t          req,
    input  logic [pidaw_pkg::ACC_W-1:0]  opa,
    input  logic [pidaw_pkg::OPB_W-1:0]  opb,
    output logic                         done,
    output logic [pidaw_pkg::ACC_W-1:0]  result
);

    localparam int ACC_W = pidaw_pkg::ACC_W;
    localparam int SRC_W = pidaw_pkg::SRC_W;
    localparam int MUL_W = pidaw_pkg::MUL_W;
    localparam int OPB_W = pidaw_pkg::OPB_W;
    localparam int CNT_W = pidaw_pkg::CNT_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [MUL_W-1:0] mlt_reg, mlt_next;
    logic [OPB_W-1:0] dvs_reg, dvs_next;
    logic [OPB_W-1:0] rem_reg, rem_next;

    logic [OPB_W:0]   r2;
    logic [OPB_W:0]   r2_sub;
    logic             ge;
    logic [ACC_W-1:0] addend;

    always_comb
    begin
        r2     = {rem_reg, acc_reg[ACC_W-1]};
        r2_sub = r2 - {1'b0, dvs_reg};
        ge     = (r2 >= {1'b0, dvs_reg});
        addend = mlt_reg[MUL_W-1] ? ACC_W'(src_reg) : '0;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        acc_next  = acc_reg;
        src_next  = src_reg;
        mlt_next  = mlt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.div;
            acc_next  = req.div ? opa : '0;
            src_next  = opa[SRC_W-1:0];
            mlt_next  = opb[MUL_W-1:0];
            dvs_next  = opb;
            rem_next  = '0;
            cnt_next  = req.div ? CNT_W'(ACC_W) : CNT_W'(MUL_W);
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // shift the dividend out at the top, the quotient in at the bottom
                acc_next = {acc_reg[ACC_W-2:0], ge};
                rem_next = ge ? r2_sub[OPB_W-1:0] : r2[OPB_W-1:0];
            end
            else
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0} + addend;
                mlt_next = {mlt_reg[MUL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        acc_reg <= acc_next;
        src_reg <= src_next;
        mlt_reg <= mlt_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### sv/pid_controller_antiwindup_unit.sv
// Updates are taken one at a time. Zero elapsed time skips all but the
// proportional term; with the derivative filter off the filter multiply and
// divide are skipped. Each multiply and divide runs on the shared
// multiply/divide unit, one bit per cycle.
// The result sits in an output register. Reset clears integral, last sample
// and filtered rate and loads register defaults.
// ---------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// PID with derivative on measurement, integral band and conditional integration.
// ---------------------------------------------------------------------------
module pid_controller_antiwindup_unit #(
    parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data,
    pidaw_in_if.sink                          req,
    pidaw_out_if.source                       rsp
);

    localparam int EW    = SAMPLE_WIDTH + 1;
    localparam int ACC_W = pidaw_pkg::ACC_W;
    localparam int OPB_W = pidaw_pkg::OPB_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_P     = 4'd1;
    localparam logic [3:0] S_EP    = 4'd2;
    localparam logic [3:0] S_CAND  = 4'd3;
    localparam logic [3:0] S_RATE  = 4'd4;
    localparam logic [3:0] S_FMUL  = 4'd5;
    localparam logic [3:0] S_FDIV  = 4'd6;
    localparam logic [3:0] S_I     = 4'd7;
    localparam logic [3:0] S_D     = 4'd8;
    localparam logic [3:0] S_CLAMP = 4'd9;

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    function automatic logic signed [63:0] sat_term(input logic [ACC_W-1:0] m,
                                                    input logic neg);
        logic [63:0] t;
        t = (m > ACC_W'(pidaw_pkg::TERM_LIM)) ? pidaw_pkg::TERM_LIM : m[63:0];
        return neg ? $signed(-t) : $signed(t);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? $signed(pidaw_pkg::INT64_MIN) : $signed(pidaw_pkg::INT64_MAX);
        return s[63:0];
    endfunction

    // configuration
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [16:0] band_reg;
    logic signed [15:0] dlo_reg, dhi_reg;
    logic        [23:0] tau_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            band_reg   <= pidaw_pkg::BAND_RST;
            dlo_reg    <= pidaw_pkg::DRIVE_LOW_RST;
            dhi_reg    <= pidaw_pkg::DRIVE_HIGH_RST;
            tau_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                pidaw_pkg::REG_GAIN_P:     gain_p_reg <= cfg_data;
                pidaw_pkg::REG_GAIN_I:     gain_i_reg <= cfg_data;
                pidaw_pkg::REG_GAIN_D:     gain_d_reg <= cfg_data;
                pidaw_pkg::REG_BAND:       band_reg   <= cfg_data[16:0];
                pidaw_pkg::REG_DRIVE_LOW:  dlo_reg    <= cfg_data[15:0];
                pidaw_pkg::REG_DRIVE_HIGH: dhi_reg    <= cfg_data[15:0];
                pidaw_pkg::REG_FILTER_TAU: tau_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // sequencer and state
    logic [3:0]                     state_reg, state_next;
    logic                           pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [63:0]             isum_reg, isum_next;
    logic signed [SAMPLE_WIDTH-1:0] last_reg, last_next;
    logic signed [47:0]             filt_reg, filt_next;

    logic signed [EW-1:0]           err_reg, err_next;
    logic signed [EW-1:0]           delta_reg, delta_next;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg, smp_next;
    logic        [31:0]             dt_reg, dt_next;
    logic signed [63:0]             u_reg, u_next;
    logic signed [63:0]             cand_reg, cand_next;
    logic        [63:0]             ep_reg, ep_next;
    logic signed [48:0]             diff_reg, diff_next;
    logic signed [15:0]             drive_reg, drive_next;
    logic                           sat_reg, sat_next;

    pidaw_pkg::mdu_req_t mreq;
    logic [ACC_W-1:0]    opa;
    logic [OPB_W-1:0]    opb;
    logic                mdone;
    logic [ACC_W-1:0]    mres;

    logic [EW-1:0]       err_mag, delta_mag;
    logic [48:0]         diff_mag;
    logic [63:0]         cand_mag;
    logic [47:0]         filt_mag;
    logic                band_clr;
    logic [47:0]         q_rate;
    logic signed [47:0]  rate;
    logic signed [48:0]  fsum;
    logic signed [63:0]  lo_q, hi_q, u_floor;

    pidaw_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .opa    (opa),
        .opb    (opb),
        .done   (mdone),
        .result (mres)
    );

    always_comb
    begin
        err_mag   = err_reg[EW-1] ? EW'(-err_reg) : EW'(err_reg);
        delta_mag = delta_reg[EW-1] ? EW'(-delta_reg) : EW'(delta_reg);
        diff_mag  = diff_reg[48] ? 49'(-diff_reg) : 49'(diff_reg);
        cand_mag  = cand_reg[63] ? 64'(-cand_reg) : 64'(cand_reg);
        filt_mag  = filt_reg[47] ? 48'(-filt_reg) : 48'(filt_reg);
        band_clr  = !band_reg[16] && (64'(err_mag) <= 64'(band_reg[15:0]));

        mreq.start = 1'b0;
        mreq.div   = 1'b0;
        opa        = '0;
        opb        = '0;
        case (state_reg)
            S_P:
            begin
                opa = ACC_W'(err_mag);
                opb = OPB_W'(mag32(gain_p_reg));
            end
            S_EP:
            begin
                opa = ACC_W'(err_mag);
                opb = OPB_W'(dt_reg);
            end
            S_RATE:
            begin
                opa      = ACC_W'(delta_mag) << FRAC_BITS;
                opb      = OPB_W'(dt_reg);
                mreq.div = 1'b1;
            end
            S_FMUL:
            begin
                opa = ACC_W'(diff_mag);
                opb = OPB_W'(dt_reg);
            end
            S_FDIV:
            begin
                opa      = mres;
                opb      = OPB_W'(dt_reg) + OPB_W'(tau_reg);
                mreq.div = 1'b1;
            end
            S_I:
            begin
                opa = ACC_W'(cand_mag);
                opb = OPB_W'(mag32(gain_i_reg));
            end
            S_D:
            begin
                opa = ACC_W'(filt_mag);
                opb = OPB_W'(mag32(gain_d_reg));
            end
            default: ;
        endcase
        if (!pend_reg && (state_reg == S_P || state_reg == S_EP || state_reg == S_RATE
                          || state_reg == S_FMUL || state_reg == S_FDIV
                          || state_reg == S_I || state_reg == S_D))
            mreq.start = 1'b1;

        q_rate  = (mres > ACC_W'(pidaw_pkg::RATE_MAX)) ? pidaw_pkg::RATE_MAX : mres[47:0];
        rate    = delta_reg[EW-1] ? -$signed(q_rate) : $signed(q_rate);
        fsum    = diff_reg[48] ? 49'(filt_reg) - $signed(49'(mres[48:0]))
                               : 49'(filt_reg) + $signed(49'(mres[48:0]));
        lo_q    = 64'(dlo_reg) <<< FRAC_BITS;
        hi_q    = 64'(dhi_reg) <<< FRAC_BITS;
        u_floor = u_reg >>> FRAC_BITS;
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        isum_next      = isum_reg;
        last_next      = last_reg;
        filt_next      = filt_reg;
        err_next       = err_reg;
        delta_next     = delta_reg;
        smp_next       = smp_reg;
        dt_next        = dt_reg;
        u_next         = u_reg;
        cand_next      = cand_reg;
        ep_next        = ep_reg;
        diff_next      = diff_reg;
        drive_next     = drive_reg;
        sat_next       = sat_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        if (mreq.start)
            pend_next = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    err_next   = EW'(req.target) - EW'(req.sample);
                    delta_next = EW'(req.sample) - EW'(last_reg);
                    smp_next   = req.sample;
                    dt_next    = req.elapsed_us;
                    pend_next  = 1'b0;
                    state_next = S_P;
                end
            end
            S_P:
            begin
                if (pend_reg && mdone)
                begin
                    pend_next  = 1'b0;
                    u_next     = sat_term(mres, gain_p_reg[31] ^ err_reg[EW-1]);
                    state_next = (dt_reg == '0) ? S_CLAMP : S_EP;
                end
            end
            S_EP:
            begin
                // clear inside the error band before forming the candidate
                if (!pend_reg && band_clr)
                    isum_next = '0;
                if (pend_reg && mdone)
                begin
                    pend_next  = 1'b0;
                    ep_next    = (mres > ACC_W'(pidaw_pkg::INT64_MAX)) ?
                                 pidaw_pkg::INT64_MAX : mres[63:0];
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                cand_next  = sat_add(isum_reg, err_reg[EW-1] ? $signed(-ep_reg)
                                                             : $signed(ep_reg));
                state_next = S_RATE;
            end
            S_RATE:
            begin
                if (pend_reg && mdone)
                begin
                    pend_next = 1'b0;
                    if (tau_reg == '0)
                    begin
                        filt_next  = rate;
                        state_next = S_I;
                    end
                    else
                    begin
                        diff_next  = 49'(rate) - 49'(filt_reg);
                        state_next = S_FMUL;
                    end
                end
            end
            S_FMUL:
            begin
                if (pend_reg && mdone)
                begin
                    pend_next  = 1'b0;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (pend_reg && mdone)
                begin
                    pend_next  = 1'b0;
                    filt_next  = fsum[47:0];
                    state_next = S_I;
                end
            end
            S_I:
            begin
                if (pend_reg && mdone)
                begin
                    pend_next  = 1'b0;
                    u_next     = u_reg + sat_term(mres, gain_i_reg[31] ^ cand_reg[63]);
                    state_next = S_D;
                end
            end
            S_D:
            begin
                if (pend_reg && mdone)
                begin
                    pend_next  = 1'b0;
                    u_next     = u_reg - sat_term(mres >> FRAC_BITS,
                                                  gain_d_reg[31] ^ filt_reg[47]);
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    if (u_reg < lo_q)
                    begin
                        drive_next = dlo_reg;
                        sat_next   = 1'b1;
                    end
                    else if (u_reg > hi_q)
                    begin
                        drive_next = dhi_reg;
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        drive_next = u_floor[15:0];
                        sat_next   = 1'b0;
                    end
                    if (dt_reg != '0 && !(u_reg < lo_q) && !(u_reg > hi_q))
                        isum_next = cand_reg;
                    last_next  = smp_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            isum_reg      <= '0;
            last_reg      <= '0;
            filt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            isum_reg      <= isum_next;
            last_reg      <= last_next;
            filt_reg      <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        delta_reg <= delta_next;
        smp_reg   <= smp_next;
        dt_reg    <= dt_next;
        u_reg     <= u_next;
        cand_reg  <= cand_next;
        ep_reg    <= ep_next;
        diff_reg  <= diff_next;
        drive_reg <= drive_next;
        sat_reg   <= sat_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.drive     = drive_reg;
    assign rsp.saturated = sat_reg;

endmodule

### tb/pidaw_tb_if.sv
// ---------------------------------------------------------------------------
// pidaw_tb_if
// Configuration write port bundle used by the controller testbench.
// ---------------------------------------------------------------------------
interface pidaw_cfg_if;
    logic                                wen;
    logic [pidaw_pkg::CFG_IDX_W-1:0]     index;
    logic [pidaw_pkg::CFG_DATA_W-1:0]    data;

    modport source (output wen, index, data);
    modport sink   (input wen, index, data);
endinterface

### tb/pid_controller_antiwindup_unit_tb.sv
// ---------------------------------------------------------------------------
// pid_controller_antiwindup_unit_tb
// Drives setpoint/measurement updates through several gain, band, clamp and
// filter settings and checks every drive word against a cycle-free model.
// ---------------------------------------------------------------------------
class drive_scoreboard;
    logic signed [31:0] kp, ki, kd;
    logic signed [16:0] band;
    logic signed [15:0] lim_lo, lim_hi;
    logic [23:0]        tau;
    logic signed [63:0] integ;
    logic signed [15:0] prev_smp;
    logic signed [47:0] frate;
    logic [16:0]        exp_q[$];
    int                 errors;
    int                 checked;

    function void reset_state();
        kp = 0; ki = 0; kd = 0; band = -1;
        lim_lo = -32768; lim_hi = 32767; tau = 0;
        integ = 0; prev_smp = 0; frate = 0;
        exp_q.delete();
        errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            pidaw_pkg::REG_GAIN_P:     kp = v;
            pidaw_pkg::REG_GAIN_I:     ki = v;
            pidaw_pkg::REG_GAIN_D:     kd = v;
            pidaw_pkg::REG_BAND:       band = v[16:0];
            pidaw_pkg::REG_DRIVE_LOW:  lim_lo = v[15:0];
            pidaw_pkg::REG_DRIVE_HIGH: lim_hi = v[15:0];
            pidaw_pkg::REG_FILTER_TAU: tau = v[23:0];
            default: ;
        endcase
    endfunction

    // magnitude product, shifted, saturated to +-2^61
    function logic signed [63:0] term(logic signed [63:0] a, logic signed [63:0] b,
                                      int sh);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        logic [63:0]  r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p = (128'(ma) * 128'(mb)) >> sh;
        r = (p > 128'(pidaw_pkg::TERM_LIM)) ? pidaw_pkg::TERM_LIM : p[63:0];
        return (a[63] != b[63]) ? -$signed(r) : $signed(r);
    endfunction

    function void note_update(logic signed [15:0] tgt, logic signed [15:0] smp,
                              logic [31:0] dt);
        logic signed [63:0]  err, u, cand, delta, rate, diff, lo_q, hi_q, drv, sum;
        logic [63:0]         me, q, ep;
        logic [127:0]        qq;
        logic                sat;
        err = 64'(tgt) - 64'(smp);
        me = err[63] ? -err : err;
        cand = integ;
        u = term(kp, err, 0);
        if (dt != 0)
        begin
            delta = 64'(smp) - 64'(prev_smp);
            if (!band[16] && me <= 64'(band))
                integ = 0;
            q = ((delta[63] ? -delta : delta) << 16) / 64'(dt);
            if (q > 64'(pidaw_pkg::RATE_MAX))
                q = 64'(pidaw_pkg::RATE_MAX);
            rate = delta[63] ? -$signed(q) : $signed(q);
            if (tau != 0)
            begin
                diff = rate - 64'(frate);
                qq = 128'(diff[63] ? -diff : diff) * 128'(dt) / (128'(tau) + 128'(dt));
                frate = 64'(frate) + (diff[63] ? -$signed(qq[63:0]) : $signed(qq[63:0]));
            end
            else
                frate = rate[47:0];
            ep = me * 64'(dt);
            if (ep > pidaw_pkg::INT64_MAX)
                ep = pidaw_pkg::INT64_MAX;
            sum = integ + (err[63] ? -$signed(ep) : $signed(ep));
            if (!err[63] && !integ[63] && sum[63])
                cand = pidaw_pkg::INT64_MAX;
            else if (err[63] && integ[63] && !sum[63])
                cand = pidaw_pkg::INT64_MIN;
            else
                cand = sum;
            u = u + term(ki, cand, 0) - term(kd, 64'(frate), 16);
        end
        lo_q = 64'(lim_lo) <<< 16;
        hi_q = 64'(lim_hi) <<< 16;
        if (u < lo_q)
        begin
            drv = lim_lo; sat = 1;
        end
        else if (u > hi_q)
        begin
            drv = lim_hi; sat = 1;
        end
        else
        begin
            drv = u >>> 16;
            sat = 0;
        end
        if (dt != 0 && !sat)
            integ = cand;
        prev_smp = smp;
        exp_q.push_back({drv[15:0], sat});
    endfunction

    function void check_drive(logic [15:0] drv, logic sat);
        logic [16:0] e;
        checked++;
        if (exp_q.size() == 0)
        begin
            report("unexpected drive word", 0, {drv, sat});
            return;
        end
        e = exp_q.pop_front();
        if (e[16:1] !== drv)
            report("drive mismatch", e[16:1], drv);
        if (e[0] !== sat)
            report("saturated mismatch", e[0], sat);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("ERROR %s: expected %0h got %0h (result %0d)", what, want, got, checked);
    endfunction
endclass

module pid_controller_antiwindup_unit_tb;

    // index with no register behind it
    localparam logic [pidaw_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic clk;
    logic rst_n;
    int   cycles;
    int   sent;
    bit   quiet;
    drive_scoreboard sb;

    pidaw_cfg_if cfg ();
    pidaw_in_if  req ();
    pidaw_out_if rsp ();

    pid_controller_antiwindup_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg.wen),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("Timeout with %0d drive words pending", sb.exp_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random stall, check on handshake
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_drive(rsp.drive, rsp.saturated);
        if (rst_n)
            rsp.ready <= quiet || ($urandom_range(99) >= 8);
    end

    // write enable stays up between back to back writes; set_phase drops it
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg.wen <= 1; cfg.index <= idx; cfg.data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (sb.exp_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // valid stays up after the handshake until the next word or a drain
    task automatic send_update(logic [15:0] tgt, logic [15:0] smp, logic [31:0] dt);
        while (!quiet && $urandom_range(99) < 8)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1; req.target <= tgt; req.sample <= smp; req.elapsed_us <= dt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_update(tgt, smp, dt);
        sent++;
    endtask

    function automatic logic [31:0] rand_dt();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            2: return $urandom;
            3: return 1;
            default: return $urandom_range(5000, 1);
        endcase
    endfunction

    function automatic logic [15:0] rand_val(logic [15:0] near);
        case ($urandom_range(5))
            0: return $urandom;
            1: return 16'h8000;
            2: return 16'h7FFF;
            default: return near + 16'($urandom_range(400)) - 16'd200;
        endcase
    endfunction

    task automatic set_phase(int p);
        logic [31:0] g;
        case (p % 6)
            0:
            begin
                write_reg(pidaw_pkg::REG_GAIN_P, 32'h0001_0000);
                write_reg(pidaw_pkg::REG_GAIN_I, 32'd20);
                write_reg(pidaw_pkg::REG_GAIN_D, 32'h0000_8000);
                write_reg(pidaw_pkg::REG_BAND, 32'h1FFFF);
                write_reg(pidaw_pkg::REG_DRIVE_LOW, 32'hFFFF_8000);
                write_reg(pidaw_pkg::REG_DRIVE_HIGH, 32'h7FFF);
                write_reg(pidaw_pkg::REG_FILTER_TAU, 0);
            end
            1:
            begin
                write_reg(pidaw_pkg::REG_GAIN_P, 32'h8000_0000);
                write_reg(pidaw_pkg::REG_GAIN_I, 32'h7FFF_FFFF);
                write_reg(pidaw_pkg::REG_GAIN_D, 32'h8000_0000);
                write_reg(pidaw_pkg::REG_BAND, 32'h0FFFF);
                write_reg(pidaw_pkg::REG_FILTER_TAU, 32'hFF_FFFF);
            end
            2:
            begin
                write_reg(pidaw_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
                write_reg(pidaw_pkg::REG_GAIN_I, 32'h8000_0000);
                write_reg(pidaw_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
                write_reg(pidaw_pkg::REG_BAND, 0);
                write_reg(pidaw_pkg::REG_DRIVE_LOW, 32'h0000_0100);
                write_reg(pidaw_pkg::REG_DRIVE_HIGH, 32'hFFFF_FF00);
                write_reg(pidaw_pkg::REG_FILTER_TAU, 1);
                write_reg(REG_SPARE, 32'hDEAD_BEEF);
            end
            default:
            begin
                g = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h4_0000);
                write_reg(pidaw_pkg::REG_GAIN_P, $urandom_range(1) ? g : -g);
                write_reg(pidaw_pkg::REG_GAIN_I, $urandom_range(400) - 200);
                write_reg(pidaw_pkg::REG_GAIN_D,
                          $urandom_range(1) ? $urandom : $urandom_range(70000));
                write_reg(pidaw_pkg::REG_BAND,
                          $urandom_range(2) == 0 ? 32'h1FFFF : $urandom_range(3000));
                write_reg(pidaw_pkg::REG_DRIVE_LOW, -$urandom_range(32768));
                write_reg(pidaw_pkg::REG_DRIVE_HIGH, $urandom_range(32767));
                write_reg(pidaw_pkg::REG_FILTER_TAU,
                          $urandom_range(1) ? $urandom_range(50000) : 0);
            end
        endcase
        cfg.wen <= 0;
    endtask

    initial
    begin
        logic [15:0] tgt, smp;
        sb = new();
        sb.reset_state();
        sent = 0;
        quiet = 0;
        rst_n = 0;
        cfg.wen = 0; cfg.index = pidaw_pkg::REG_GAIN_P; cfg.data = 0;
        req.valid = 0; req.target = 0; req.sample = 0; req.elapsed_us = 0;
        rsp.ready = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, extremes, zero time, band clear, windup
        send_update(16'h7FFF, 16'h8000, 0);
        drain();
        set_phase(0);
        send_update(16'h7FFF, 16'h8000, 0);
        send_update(16'h8000, 16'h7FFF, 1);
        send_update(16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_update(16'h0064, 16'h0000, 1000);
        send_update(16'h0064, 16'h0060, 0);
        drain();
        set_phase(1);
        send_update(16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
        send_update(16'h0005, 16'h0005, 100);
        send_update(16'h8000, 16'h7FFF, 32'h8000_0000);
        send_update(16'h0000, 16'hFFFF, 0);
        drain();
        set_phase(2);
        send_update(16'h0001, 16'h0001, 1);
        send_update(16'h0010, 16'h0000, 10);
        send_update(16'hFFF0, 16'h0000, 10);
        send_update(16'h5555, 16'hAAAA, 32'h5555_5555);
        send_update(16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
        drain();

        for (int p = 3; p < 12; p++)
        begin
            set_phase(p);
            quiet = (p == 5);
            tgt = $urandom;
            smp = tgt;
            for (int k = 0; k < 160; k++)
            begin
                if ($urandom_range(19) == 0)
                    tgt = $urandom;
                smp = rand_val(smp);
                send_update(rand_val(tgt), smp, rand_dt());
                // hold off until the pipe is empty
                if (k == 80)
                    drain();
            end
            quiet = 0;
            drain();
        end

        drain();
        $display("Sent %0d controller updates over 12 register settings", sent);
        $display("Checked %0d drive words, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### pid_controller_antiwindup_unit.f
sv/pidaw_pkg.sv
sv/pidaw_if.sv
sv/pidaw_mdu.sv
sv/pid_controller_antiwindup_unit.sv
tb/pidaw_tb_if.sv
tb/pid_controller_antiwindup_unit_tb.sv
